// ===== src/timer_slot_bank_top_assert.svh =====
// ---------------------------------------------------------------------------
// timer slot bank assertion macros
// concurrent assertion wrappers shared by the rtl files of the timer bank
// ---------------------------------------------------------------------------
`ifndef TIMER_SLOT_BANK_TOP_ASSERT_SVH
`define TIMER_SLOT_BANK_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// assertion sampled on the clock, off while reset is held
`define TSB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion sampled on the clock, also checked during reset
`define TSB_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSB_ASSERT(label, clk, rst_n, prop, msg)

`define TSB_ASSERT_NORST(label, clk, prop, msg)

`endif

`endif

// ===== src/tsb_pkg.sv =====
// ---------------------------------------------------------------------------
// tsb_pkg
// types and constants shared by the timer slot bank modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsb_pkg;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_POLL  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_STARTED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    // divide by ten: multiply by reciprocal, exact for any 32-bit value
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          RELOAD_W    = 29;
    localparam int          TICK_W      = 64;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] period_ms;
        logic        repeat_flag;
        logic [3:0]  slot_sel;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot_id;
        logic       last;
    } t_out_item;

    // one slot as held in the slot memory
    typedef struct packed {
        logic                rep;
        logic [RELOAD_W-1:0] reload;
        logic [TICK_W-1:0]   deadline;
    } t_slot_entry;

    // controller to datapath commands
    typedef struct packed {
        logic load_fields;
        logic clr_idx;
        logic inc_idx;
        logic do_stop;
        logic do_tick;
        logic do_mul;
        logic start_write;
        logic emit_start;
        logic emit_full;
        logic poll_act;
        logic emit_pend_last;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic idx_last;
        logic hit;
        logic pend_valid;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/tsb_ram.sv =====
// ---------------------------------------------------------------------------
// tsb_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tsb_datapath.sv =====
// ---------------------------------------------------------------------------
// tsb_datapath
// tick counter, slot active bits, slot memory, scan index and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timer_slot_bank_top_assert.svh"

module tsb_datapath #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsb_pkg::t_in_item   i_in,
    input  tsb_pkg::t_ctrl_cmd  i_cmd,
    output tsb_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tsb_pkg::t_out_item  o_out
);

    import tsb_pkg::*;

    localparam int SW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_W = $bits(t_slot_entry);

    logic [SW-1:0]        r_idx, n_idx;
    logic [TICK_W-1:0]    r_now, n_now;
    logic [NUM_SLOTS-1:0] r_active, n_active;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;
    logic                 r_pend_valid, n_pend_valid;
    logic [SW-1:0]        r_pend_id;
    logic [31:0]          r_interval;
    logic                 r_repeat;
    logic [63:0]          r_prod;

    logic [RELOAD_W-1:0]  start_reload;
    logic [RELOAD_W-1:0]  base_reload;
    logic [TICK_W-1:0]    new_deadline;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_slot_entry          rd_entry;
    t_slot_entry          wr_entry;
    logic                 ram_we;
    logic                 sel_in_range;
    logic [SW-1:0]        sel_idx;
    logic                 out_free;
    logic                 hit;

    assign start_reload = r_prod[DIV10_SHIFT +: RELOAD_W];
    assign rd_entry     = t_slot_entry'(ram_rdata);
    assign sel_in_range = 32'(i_in.slot_sel) < 32'(NUM_SLOTS);
    assign sel_idx      = SW'(i_in.slot_sel);
    assign out_free     = !r_out_valid || i_out_ready;
    assign hit          = r_active[r_idx] && (r_now >= rd_entry.deadline);

    // status back to the controller
    assign o_status.slot_free  = !r_active[r_idx];
    assign o_status.idx_last   = (r_idx == SW'(NUM_SLOTS - 1));
    assign o_status.hit        = hit;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = out_free;

    // new deadline: one adder shared by start and reschedule
    assign base_reload  = i_cmd.start_write ? start_reload : rd_entry.reload;
    assign new_deadline = r_now + TICK_W'(base_reload);

    always_comb begin
        wr_entry.rep      = i_cmd.start_write ? r_repeat : 1'b1;
        wr_entry.reload   = base_reload;
        wr_entry.deadline = new_deadline;
    end

    assign ram_we = i_cmd.start_write || (i_cmd.poll_act && rd_entry.rep);

    // slot memory, read address runs one step ahead of the scan index
    tsb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS),
        .AW    (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (wr_entry),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    // next state of index, counter, active bits, pending and result
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.clr_idx) begin
            n_idx = '0;
        end else if (i_cmd.inc_idx) begin
            n_idx = r_idx + SW'(1);
        end

        n_now = r_now;
        if (i_cmd.do_tick) begin
            n_now = r_now + TICK_W'(1);
        end

        n_active = r_active;
        if (i_cmd.do_stop && sel_in_range) begin
            n_active[sel_idx] = 1'b0;
        end
        if (i_cmd.start_write) begin
            n_active[r_idx] = 1'b1;
        end
        if (i_cmd.poll_act && !rd_entry.rep) begin
            n_active[r_idx] = 1'b0;
        end

        n_pend_valid = r_pend_valid;
        if (i_cmd.poll_act) begin
            n_pend_valid = 1'b1;
        end else if (i_cmd.emit_pend_last) begin
            n_pend_valid = 1'b0;
        end

        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (i_cmd.emit_start) begin
            n_out_valid = 1'b1;
            n_out.kind    = KIND_STARTED;
            n_out.slot_id = 4'(r_idx);
            n_out.last    = 1'b1;
        end else if (i_cmd.emit_full) begin
            n_out_valid = 1'b1;
            n_out.kind    = KIND_FULL;
            n_out.slot_id = 4'd0;
            n_out.last    = 1'b1;
        end else if (i_cmd.poll_act && r_pend_valid) begin
            n_out_valid = 1'b1;
            n_out.kind    = KIND_EXPIRED;
            n_out.slot_id = 4'(r_pend_id);
            n_out.last    = 1'b0;
        end else if (i_cmd.emit_pend_last) begin
            n_out_valid = 1'b1;
            n_out.kind    = KIND_EXPIRED;
            n_out.slot_id = 4'(r_pend_id);
            n_out.last    = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_now        <= '0;
            r_active     <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_now        <= n_now;
            r_active     <= n_active;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.poll_act) begin
            r_pend_id <= r_idx;
        end
        if (i_cmd.load_fields) begin
            r_interval <= i_in.period_ms;
            r_repeat   <= i_in.repeat_flag;
        end
        if (i_cmd.do_mul) begin
            r_prod <= 64'(r_interval) * 64'(DIV10_RECIP);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TSB_ASSERT(a_start_free_slot, i_clk, i_rst_n, i_cmd.start_write |-> !r_active[r_idx], "start wrote a busy slot")
    `TSB_ASSERT(a_emit_out_free, i_clk, i_rst_n, (i_cmd.emit_start || i_cmd.emit_full || i_cmd.emit_pend_last || (i_cmd.poll_act && r_pend_valid)) |-> out_free, "result overwrote an untaken result")
    `TSB_ASSERT_NORST(a_reset_clears, i_clk, !i_rst_n |=> (r_active == '0 && !r_out_valid && !r_pend_valid), "reset left slots or results behind")

endmodule

// ===== src/tsb_ctrl.sv =====
// ---------------------------------------------------------------------------
// tsb_ctrl
// command sequencer: accepts a command and steps the slot scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timer_slot_bank_top_assert.svh"

module tsb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_cmd,
    output logic                o_in_ready,
    input  tsb_pkg::t_dp_status i_status,
    output tsb_pkg::t_ctrl_cmd  o_cmd
);

    import tsb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_MUL      = 5'b00010,
        S_START    = 5'b00100,
        S_POLL     = 5'b01000,
        S_POLL_END = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_in_cmd)
                        CMD_START: begin
                            o_cmd.load_fields = 1'b1;
                            o_cmd.clr_idx     = 1'b1;
                            n_state           = S_MUL;
                        end
                        CMD_STOP: begin
                            o_cmd.do_stop = 1'b1;
                        end
                        CMD_TICK: begin
                            o_cmd.do_tick = 1'b1;
                        end
                        CMD_POLL: begin
                            o_cmd.clr_idx = 1'b1;
                            n_state       = S_POLL;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = S_START;
            end
            S_START: begin
                // wait for a free result register, then look for a free slot
                if (i_status.out_free) begin
                    if (i_status.slot_free) begin
                        o_cmd.start_write = 1'b1;
                        o_cmd.emit_start  = 1'b1;
                        n_state           = S_IDLE;
                    end else if (i_status.idx_last) begin
                        o_cmd.emit_full = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                    end
                end
            end
            S_POLL: begin
                // hold the scan when an earlier expiry cannot be pushed out
                if (!(i_status.hit && i_status.pend_valid && !i_status.out_free)) begin
                    o_cmd.poll_act = i_status.hit;
                    if (i_status.idx_last) begin
                        n_state = S_POLL_END;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                    end
                end
            end
            S_POLL_END: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit_pend_last = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `TSB_ASSERT(a_idle_no_pending, i_clk, i_rst_n, (r_state == S_IDLE) |-> !i_status.pend_valid, "expiry left pending after poll")

endmodule

// ===== src/timer_slot_bank_top.sv =====
// ---------------------------------------------------------------------------
// timer_slot_bank_top
// bank of timer slots driven by a 64-bit tick counter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Stop and tick commands are taken in S_IDLE and give no result. A start is
// taken in S_IDLE, then S_MUL turns period_ms into ticks through the
// divide-by-ten multiplier, then S_START scans the active bits one slot a
// cycle until the lowest free slot is found, or reports full at the last
// slot; the scan waits while the result register still holds an untaken
// result. A poll is taken in S_IDLE, then S_POLL scans the slot memory one
// slot read a cycle, holding while a new expiry is found and the result
// register still holds an untaken expiry, and S_POLL_END emits the last
// expiry, if any, once the result register is free. Results pass through a
// one-deep output register, so a new command is taken while the last result
// waits. Reset clears the active bits; there is no clearing pass over the slot memory.
module timer_slot_bank_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tsb_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tsb_pkg::t_out_item o_out
);

    import tsb_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // command sequencer
    tsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    // slot storage and arithmetic
    tsb_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench for timer_slot_bank_top
// drives start, stop, tick and poll commands through the input channel and
// checks each start report and expiry against an in-bench timer slot model,
// with random gaps on the command side and random stalls on the result side
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tsb_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int MS_PER_TICK = 10;
    localparam int RANDOM_CMDS = 300;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out;

    // commands waiting to be driven, results still owed by the block
    t_in_item  cmd_backlog[$];
    t_out_item slot_reports_due[$];

    // timer slot model state
    logic [TICK_W-1:0]   model_now;
    bit                  model_active [NUM_SLOTS];
    bit                  model_repeat [NUM_SLOTS];
    logic [RELOAD_W-1:0] model_reload [NUM_SLOTS];
    logic [TICK_W-1:0]   model_deadline [NUM_SLOTS];

    int fail_count      = 0;
    int cmds_taken      = 0;
    int starts_taken    = 0;
    int stops_taken     = 0;
    int ticks_taken     = 0;
    int polls_taken     = 0;
    int results_checked = 0;
    int refusals_seen   = 0;
    int expiries_seen   = 0;
    int gap_left        = 0;
    int stall_left      = 0;

    // stretches of back-to-back traffic on both sides
    wire calm = ((cmds_taken / 40) % 4) == 3;

    timer_slot_bank_top #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_in_item make_cmd(logic [1:0] cmd, logic [31:0] period_ms,
                                          logic repeat_flag, logic [3:0] slot_sel);
        t_in_item it;
        it.cmd         = cmd;
        it.period_ms   = period_ms;
        it.repeat_flag = repeat_flag;
        it.slot_sel    = slot_sel;
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    // update the slot model for one command and queue the results it owes
    task automatic apply_timer_cmd(input t_in_item it);
        t_out_item           res;
        bit                  fired [NUM_SLOTS];
        int                  last_fired;
        bit                  placed;
        logic [RELOAD_W-1:0] reload;
        case (it.cmd)
            CMD_START: begin
                placed = 1'b0;
                reload = RELOAD_W'(it.period_ms / MS_PER_TICK);
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!placed && !model_active[i]) begin
                        placed            = 1'b1;
                        model_active[i]   = 1'b1;
                        model_repeat[i]   = it.repeat_flag;
                        model_reload[i]   = reload;
                        model_deadline[i] = model_now + TICK_W'(reload);
                        res.kind          = KIND_STARTED;
                        res.slot_id       = 4'(i);
                        res.last          = 1'b1;
                        slot_reports_due.push_back(res);
                    end
                end
                if (!placed) begin
                    res.kind    = KIND_FULL;
                    res.slot_id = '0;
                    res.last    = 1'b1;
                    slot_reports_due.push_back(res);
                end
            end
            CMD_STOP: begin
                if (it.slot_sel < NUM_SLOTS) model_active[it.slot_sel] = 1'b0;
            end
            CMD_TICK: begin
                model_now = model_now + 1'b1;
            end
            default: begin
                // poll: scan in index order, the last expiry carries last
                last_fired = -1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    fired[i] = model_active[i] && (model_now >= model_deadline[i]);
                    if (fired[i]) begin
                        last_fired = i;
                        if (model_repeat[i])
                            model_deadline[i] = model_now + TICK_W'(model_reload[i]);
                        else
                            model_active[i] = 1'b0;
                    end
                end
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (fired[i]) begin
                        res.kind    = KIND_EXPIRED;
                        res.slot_id = 4'(i);
                        res.last    = (i == last_fired);
                        slot_reports_due.push_back(res);
                    end
                end
            end
        endcase
    endtask

    // compare one result transaction with the oldest one owed
    task automatic check_slot_report(input t_out_item got);
        t_out_item want;
        if (slot_reports_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d slot %0d last %0d",
                                      got.kind, got.slot_id, got.last));
        end else begin
            want = slot_reports_due.pop_front();
            results_checked++;
            if (want.kind == KIND_FULL) refusals_seen++;
            if (want.kind == KIND_EXPIRED) expiries_seen++;
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.slot_id !== want.slot_id)
                report_mismatch($sformatf("slot_id %0d, expected %0d",
                                          got.slot_id, want.slot_id));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d (slot %0d)",
                                          got.last, want.last, want.slot_id));
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (in_valid && !o_in_ready) begin
            // hold the transaction until it is taken
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() > 0) begin
            in_item  <= cmd_backlog.pop_front();
            in_valid <= 1'b1;
            gap_left <= calm ? 0 : pick_gap();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result side back pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0 && !calm) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready  <= 1'b1;
            stall_left <= (!calm && $urandom_range(0, 9) < 3) ? pick_gap() : 0;
        end
    end

    // monitor: check results, then feed taken commands to the model
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) check_slot_report(o_out);
            if (in_valid && o_in_ready) begin
                apply_timer_cmd(in_item);
                cmds_taken <= cmds_taken + 1;
                case (in_item.cmd)
                    CMD_START: starts_taken <= starts_taken + 1;
                    CMD_STOP:  stops_taken  <= stops_taken + 1;
                    CMD_TICK:  ticks_taken  <= ticks_taken + 1;
                    default:   polls_taken  <= polls_taken + 1;
                endcase
            end
        end
    end

    // random command with mostly short intervals so slots keep expiring
    function automatic t_in_item random_cmd();
        t_in_item it;
        int       r;
        it.period_ms   = $urandom();
        it.repeat_flag = 1'($urandom_range(0, 1));
        it.slot_sel    = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 30) begin
            it.cmd = CMD_START;
            r = $urandom_range(0, 99);
            if (r < 60)      it.period_ms = $urandom_range(0, 80);
            else if (r < 80) it.period_ms = $urandom_range(0, 9);
            else if (r < 92) it.period_ms = $urandom_range(81, 400);
        end else if (r < 42) begin
            it.cmd = CMD_STOP;
        end else if (r < 75) begin
            it.cmd = CMD_TICK;
        end else begin
            it.cmd = CMD_POLL;
        end
        return it;
    endfunction

    // stimulus and end of run
    initial begin
        int          drain;
        logic [31:0] ivl;
        model_now = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            model_active[i]   = 1'b0;
            model_repeat[i]   = 1'b0;
            model_reload[i]   = '0;
            model_deadline[i] = '0;
        end

        // poll on an empty bank, then fill every slot and one start more
        cmd_backlog.push_back(make_cmd(CMD_POLL, '0, 1'b0, '0));
        for (int i = 0; i < NUM_SLOTS; i++) begin
            case (i)
                0:         ivl = 32'd0;
                1:         ivl = 32'd9;
                2:         ivl = 32'd10;
                15:        ivl = 32'hFFFF_FFFF;
                default:   ivl = 32'(i * 10);
            endcase
            cmd_backlog.push_back(make_cmd(CMD_START, ivl, i[0], '0));
        end
        cmd_backlog.push_back(make_cmd(CMD_START, 32'd50, 1'b1, '0));
        // zero-reload slots expire at once, then one tick later
        cmd_backlog.push_back(make_cmd(CMD_POLL, '0, 1'b0, '0));
        cmd_backlog.push_back(make_cmd(CMD_TICK, '0, 1'b0, '0));
        cmd_backlog.push_back(make_cmd(CMD_POLL, '0, 1'b0, '0));
        // stop an already free slot, the top slot and a repeating slot
        cmd_backlog.push_back(make_cmd(CMD_STOP, '0, 1'b0, 4'd0));
        cmd_backlog.push_back(make_cmd(CMD_STOP, '0, 1'b0, 4'd15));
        cmd_backlog.push_back(make_cmd(CMD_STOP, '0, 1'b0, 4'd1));
        cmd_backlog.push_back(make_cmd(CMD_START, 32'd25, 1'b0, '0));

        for (int n = 0; n < RANDOM_CMDS; n++) cmd_backlog.push_back(random_cmd());

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || in_valid) @(negedge i_clk);
        drain = 0;
        while (slot_reports_due.size() != 0 && drain < 100000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (4 * NUM_SLOTS + 8) @(negedge i_clk);
        if (slot_reports_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", slot_reports_due.size()));

        $display("run covered %0d commands: %0d starts, %0d stops, %0d ticks, %0d polls",
                 cmds_taken, starts_taken, stops_taken, ticks_taken, polls_taken);
        $display("checked %0d results, %0d refused starts, %0d expiries, %0d mismatches",
                 results_checked, refusals_seen, expiries_seen, fail_count);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== timer_slot_bank_top.f =====
+incdir+src
src/tsb_pkg.sv
src/tsb_ram.sv
src/tsb_datapath.sv
src/tsb_ctrl.sv
src/timer_slot_bank_top.sv
tb/testbench.sv
